>>> hw/rtl/alu256_pkg.sv
// Shared types, widths and opcodes of the 256-bit binary ALU.
package alu256_pkg;

	localparam int NUM_WORDS = 4;
	localparam int WORD_W    = 64;
	localparam int CMD_W     = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CMD_W-1:0]  cmd_t;

	localparam cmd_t CMD_ADD = 4'd0;
	localparam cmd_t CMD_SUB = 4'd1;
	localparam cmd_t CMD_LT  = 4'd2;
	localparam cmd_t CMD_SLT = 4'd3;
	localparam cmd_t CMD_EQ  = 4'd4;
	localparam cmd_t CMD_AND = 4'd5;
	localparam cmd_t CMD_OR  = 4'd6;
	localparam cmd_t CMD_XOR = 4'd7;
	localparam cmd_t CMD_LT4 = 4'd8;

	// Per-lane partial results after the first stage.
	typedef struct packed {
		cmd_t                               cmd;
		logic [NUM_WORDS-1:0][WORD_W:0]     sum;
		logic [NUM_WORDS-1:0][WORD_W:0]     dif;
		logic [NUM_WORDS-1:0]               eqw;
		logic [NUM_WORDS-1:0]               ltw;
		logic                               slt_top;
		logic [NUM_WORDS-1:0][WORD_W-1:0]   lgc;
	} pre_t;

	// Lane carries and 256-bit flags after the second stage.
	typedef struct packed {
		cmd_t                               cmd;
		logic [NUM_WORDS-1:0][WORD_W-1:0]   sum;
		logic [NUM_WORDS-1:0][WORD_W-1:0]   dif;
		logic [NUM_WORDS-1:0]               cin;
		logic [NUM_WORDS-1:0]               bin;
		logic                               add_co;
		logic                               sub_bo;
		logic                               lt;
		logic                               slt;
		logic                               eq;
		logic                               lt4;
		logic [NUM_WORDS-1:0][WORD_W-1:0]   lgc;
		logic                               lgc_nz;
	} prop_t;

	// Final result beat.
	typedef struct packed {
		cmd_t                               cmd;
		logic [NUM_WORDS-1:0][WORD_W-1:0]   res;
		logic                               carry;
		logic                               bad;
	} post_t;

endpackage

>>> hw/rtl/alu256_if.sv
// Valid/ready channel interfaces for the ALU operand and result beats.
interface alu256_in_if;
	import alu256_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  cmd;
	word_t a_word0;
	word_t a_word1;
	word_t a_word2;
	word_t a_word3;
	word_t b_word0;
	word_t b_word1;
	word_t b_word2;
	word_t b_word3;

	modport source (
		output valid, cmd, a_word0, a_word1, a_word2, a_word3,
		       b_word0, b_word1, b_word2, b_word3,
		input  ready
	);
	modport sink (
		input  valid, cmd, a_word0, a_word1, a_word2, a_word3,
		       b_word0, b_word1, b_word2, b_word3,
		output ready
	);
endinterface

interface alu256_out_if;
	import alu256_pkg::*;

	logic  valid;
	logic  ready;
	word_t res_word0;
	word_t res_word1;
	word_t res_word2;
	word_t res_word3;
	logic  carry;
	logic  bad_opcode;

	modport source (
		output valid, res_word0, res_word1, res_word2, res_word3, carry, bad_opcode,
		input  ready
	);
	modport sink (
		input  valid, res_word0, res_word1, res_word2, res_word3, carry, bad_opcode,
		output ready
	);
endinterface

>>> hw/rtl/alu256_pre.sv
// Stage 1: per-lane 64-bit add, subtract, compare and bitwise logic.
module alu256_pre (
	input  logic              clk,
	input  logic              arst_n,
	alu256_in_if.sink         in_ch,
	output logic              valid,
	output alu256_pkg::pre_t  data,
	input  logic              ready
);
	import alu256_pkg::*;

	logic [NUM_WORDS-1:0][WORD_W-1:0] a_w;
	logic [NUM_WORDS-1:0][WORD_W-1:0] b_w;
	pre_t nxt;
	pre_t d_s1;
	logic v_s1;
	logic take;

	assign a_w = {in_ch.a_word3, in_ch.a_word2, in_ch.a_word1, in_ch.a_word0};
	assign b_w = {in_ch.b_word3, in_ch.b_word2, in_ch.b_word1, in_ch.b_word0};

	always_comb begin
		nxt     = '0;
		nxt.cmd = in_ch.cmd;
		for (int k = 0; k < NUM_WORDS; k++) begin
			nxt.sum[k] = {1'b0, a_w[k]} + {1'b0, b_w[k]};
			nxt.dif[k] = {1'b0, a_w[k]} - {1'b0, b_w[k]};
			nxt.eqw[k] = (a_w[k] == b_w[k]);
			nxt.ltw[k] = nxt.dif[k][WORD_W];
			case (in_ch.cmd)
				CMD_AND: nxt.lgc[k] = a_w[k] & b_w[k];
				CMD_OR:  nxt.lgc[k] = a_w[k] | b_w[k];
				CMD_XOR: nxt.lgc[k] = a_w[k] ^ b_w[k];
				default: nxt.lgc[k] = '0;
			endcase
		end
		// Opposite signs flip the unsigned answer of the top lane.
		nxt.slt_top = nxt.ltw[NUM_WORDS-1] ^
			(a_w[NUM_WORDS-1][WORD_W-1] ^ b_w[NUM_WORDS-1][WORD_W-1]);
	end

	assign in_ch.ready = !v_s1 || ready;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			d_s1 <= nxt;
		end
	end

	assign valid = v_s1;
	assign data  = d_s1;

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> v_s1)
		else $error("accepted beat did not reach stage 1");
endmodule

>>> hw/rtl/alu256_prop.sv
// Stage 2: carry and borrow ripple across lanes, 256-bit compare flags.
module alu256_prop (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  alu256_pkg::pre_t   in_data,
	output logic               in_ready,
	output logic               valid,
	output alu256_pkg::prop_t  data,
	input  logic               ready
);
	import alu256_pkg::*;

	prop_t nxt;
	prop_t d_s2;
	logic  v_s2;
	logic  c;
	logic  bw;
	logic  lt_low;

	always_comb begin
		nxt     = '0;
		nxt.cmd = in_data.cmd;
		nxt.lgc = in_data.lgc;
		c       = 1'b0;
		bw      = 1'b0;
		lt_low  = 1'b0;
		for (int k = 0; k < NUM_WORDS; k++) begin
			nxt.sum[k] = in_data.sum[k][WORD_W-1:0];
			nxt.dif[k] = in_data.dif[k][WORD_W-1:0];
			nxt.cin[k] = c;
			nxt.bin[k] = bw;
			c  = in_data.sum[k][WORD_W] | ((&in_data.sum[k][WORD_W-1:0]) & c);
			bw = in_data.dif[k][WORD_W] | ((in_data.dif[k][WORD_W-1:0] == '0) & bw);
			if (k < NUM_WORDS - 1) begin
				lt_low = in_data.ltw[k] | (in_data.eqw[k] & lt_low);
			end
		end
		nxt.add_co = c;
		nxt.sub_bo = bw;
		nxt.lt     = in_data.ltw[NUM_WORDS-1] | (in_data.eqw[NUM_WORDS-1] & lt_low);
		nxt.slt    = in_data.slt_top | (in_data.eqw[NUM_WORDS-1] & lt_low);
		nxt.eq     = &in_data.eqw;
		nxt.lt4    = &in_data.ltw;
		nxt.lgc_nz = |in_data.lgc;
	end

	assign in_ready = !v_s2 || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			d_s2 <= nxt;
		end
	end

	assign valid = v_s2;
	assign data  = d_s2;

	a_borrow_is_lt: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (d_s2.sub_bo == d_s2.lt))
		else $error("borrow chain disagrees with unsigned compare");
endmodule

>>> hw/rtl/alu256_post.sv
// Stage 3: final lane increment/decrement, opcode select and output register.
module alu256_post (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  alu256_pkg::prop_t  in_data,
	output logic               in_ready,
	alu256_out_if.source       out_ch
);
	import alu256_pkg::*;

	post_t nxt;
	post_t d_s3;
	logic  v_s3;

	always_comb begin
		nxt     = '0;
		nxt.cmd = in_data.cmd;
		case (in_data.cmd)
			CMD_ADD: begin
				for (int k = 0; k < NUM_WORDS; k++) begin
					nxt.res[k] = in_data.sum[k] + WORD_W'(in_data.cin[k]);
				end
				nxt.carry = in_data.add_co;
			end
			CMD_SUB: begin
				for (int k = 0; k < NUM_WORDS; k++) begin
					nxt.res[k] = in_data.dif[k] - WORD_W'(in_data.bin[k]);
				end
				nxt.carry = in_data.sub_bo;
			end
			CMD_LT: begin
				nxt.res[0] = WORD_W'(in_data.lt);
				nxt.carry  = in_data.lt;
			end
			CMD_SLT: begin
				nxt.res[0] = WORD_W'(in_data.slt);
				nxt.carry  = in_data.slt;
			end
			CMD_EQ: begin
				nxt.res[0] = WORD_W'(in_data.eq);
				nxt.carry  = in_data.eq;
			end
			CMD_LT4: begin
				nxt.res[0] = WORD_W'(in_data.lt4);
				nxt.carry  = in_data.lt4;
			end
			CMD_AND: begin
				nxt.res   = in_data.lgc;
				nxt.carry = in_data.lgc_nz;
			end
			CMD_OR, CMD_XOR: begin
				nxt.res = in_data.lgc;
			end
			default: begin
				nxt.bad = 1'b1;
			end
		endcase
	end

	assign in_ready = !v_s3 || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			d_s3 <= nxt;
		end
	end

	assign out_ch.valid      = v_s3;
	assign out_ch.res_word0  = d_s3.res[0];
	assign out_ch.res_word1  = d_s3.res[1];
	assign out_ch.res_word2  = d_s3.res[2];
	assign out_ch.res_word3  = d_s3.res[3];
	assign out_ch.carry      = d_s3.carry;
	assign out_ch.bad_opcode = d_s3.bad;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && d_s3.bad) |-> (!d_s3.carry && d_s3.res == '0))
		else $error("bad opcode beat carries a nonzero result");

	a_flag_form: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && (d_s3.cmd == CMD_LT || d_s3.cmd == CMD_SLT || d_s3.cmd == CMD_EQ ||
			d_s3.cmd == CMD_LT4)) |->
		(d_s3.res[0][WORD_W-1:1] == '0 && d_s3.res[NUM_WORDS-1:1] == '0 &&
			d_s3.carry == d_s3.res[0][0]))
		else $error("compare result is not a clean 0/1 flag");
endmodule

>>> hw/rtl/alu_256bit_binary_ops.sv
// Pipeline: three register stages; an accepted beat passes stage 1, stage 2 and stage 3
// registers before it is valid on out_ch. Throughput: one operation per cycle while
// out_ch.ready is high; a stage takes a beat when it is empty or its beat leaves in the
// same cycle, so ready ripples back through all three stages.
// Stage 1: 64-bit lane add/sub, stage 2: lane carry ripple, stage 3: apply and select.
// Reset clears the stage valid bits only; payload registers are not reset.
module alu_256bit_binary_ops (
	input  logic          clk,
	input  logic          arst_n,
	alu256_in_if.sink     in_ch,
	alu256_out_if.source  out_ch
);
	import alu256_pkg::*;

	logic  pre_valid;
	pre_t  pre_data;
	logic  pre_ready;
	logic  prop_valid;
	prop_t prop_data;
	logic  prop_ready;

	alu256_pre u_pre (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.valid  (pre_valid),
		.data   (pre_data),
		.ready  (pre_ready)
	);

	alu256_prop u_prop (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pre_valid),
		.in_data  (pre_data),
		.in_ready (pre_ready),
		.valid    (prop_valid),
		.data     (prop_data),
		.ready    (prop_ready)
	);

	alu256_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (prop_valid),
		.in_data  (prop_data),
		.in_ready (prop_ready),
		.out_ch   (out_ch)
	);
endmodule
